/* rtl/rdp_pkg.sv */
// Shared constants and register codes for the polyline simplifier.
package rdp_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int COORD_BITS_DEF = 24;
  localparam int KEPT_W         = 6;
  localparam int MAX_ERR_W      = 23;
  localparam int THR2_W         = 2 * MAX_ERR_W;
  localparam int CFG_ADDR_W     = 1;
  localparam int CFG_DATA_W     = 23;
  localparam logic [9:0] MAX_ERR_RST = 10'd256;

  localparam logic [CFG_ADDR_W-1:0] CFG_MAX_ERROR   = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_CLOSED_PATH = 1'b1;

endpackage

/* rtl/rdp_in_if.sv */
// Point input channel and result channel interfaces.
interface rdp_in_if
  import rdp_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pos_x;
  logic signed [COORD_BITS-1:0] pos_y;
  logic signed [COORD_BITS-1:0] pos_z;
  logic                         removable;
  logic                         end_of_line;

  modport source (output valid, pos_x, pos_y, pos_z, removable, end_of_line, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, removable, end_of_line, output ready);
endinterface

interface rdp_out_if
  import rdp_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [KEPT_W-1:0] kept_index;
  logic              final_kept;

  modport source (output valid, kept_index, final_kept, input ready);
  modport sink   (input valid, kept_index, final_kept, output ready);
endinterface

/* rtl/rdp_mul.sv */
// Shift-and-add multiplier shared by every product of the distance search.
module rdp_mul
  import rdp_pkg::*;
#(
  parameter int W = 52
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [W-1:0]   a,
  input  logic [W-1:0]   b,
  output logic           done,
  output logic [2*W-1:0] p
);

  logic           busy_r, busy_nxt;
  logic [2*W-1:0] a_r, a_nxt;
  logic [W-1:0]   b_r, b_nxt;
  logic [2*W-1:0] p_r, p_nxt;

  // The product is ready as soon as no multiplier bits remain.
  assign done = busy_r && (b_r == '0);
  assign p    = p_r;

  always_comb begin
    busy_nxt = busy_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    p_nxt    = p_r;
    if (start) begin
      busy_nxt = 1'b1;
      a_nxt    = (2*W)'(a);
      b_nxt    = b;
      p_nxt    = '0;
    end else if (busy_r) begin
      if (b_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        if (b_r[0]) p_nxt = p_r + a_r;
        a_nxt = a_r << 1;
        b_nxt = b_r >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) busy_r <= 1'b0;
    else        busy_r <= busy_nxt;
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
    p_r <= p_nxt;
  end

endmodule

/* rtl/polyline_douglas_peucker_simplifier_core.sv */
// Channel    Direction  Handshake          Word
// in_ch      sink       valid/ready        pos_x, pos_y, pos_z, removable, end_of_line
// out_ch     source     valid/ready        kept_index, final_kept
// cfg_*      sink       cfg_we, no wait    cfg_addr selects max_error or closed_path
// Points load at one per cycle while idle; the end_of_line word starts the simplification.
// Every product goes through one shift-add multiplier; a candidate point
// needs 3 to 10 products, a span 4 plus its candidates.
// Emission scans MAX_POINTS indices at one per cycle, stalling while the output holds a word.
// in_ch.ready is low from end_of_line until the scan ends; reset is synchronous, active low.
module polyline_douglas_peucker_simplifier_core
  import rdp_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  rdp_in_if.sink                in_ch,
  rdp_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IW   = $clog2(MAX_POINTS);
  localparam int CW   = $clog2(MAX_POINTS + 1);
  localparam int DW   = COORD_BITS + 1;
  localparam int SQ_W = 2 * COORD_BITS + 4;
  localparam int MW   = (SQ_W > THR2_W) ? SQ_W : THR2_W;
  localparam int PW   = 2 * MW;
  localparam int AW   = PW + 1;
  localparam int PTW  = 3 * COORD_BITS;
  localparam int SEW  = 2 * IW;

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_INIT   = 5'd1;
  localparam logic [4:0] ST_POP    = 5'd2;
  localparam logic [4:0] ST_SPAN   = 5'd3;
  localparam logic [4:0] ST_RDS    = 5'd4;
  localparam logic [4:0] ST_RDE    = 5'd5;
  localparam logic [4:0] ST_DIFF   = 5'd6;
  localparam logic [4:0] ST_MGO    = 5'd7;
  localparam logic [4:0] ST_MWAIT  = 5'd8;
  localparam logic [4:0] ST_CAND   = 5'd9;
  localparam logic [4:0] ST_CV     = 5'd10;
  localparam logic [4:0] ST_CMP    = 5'd11;
  localparam logic [4:0] ST_DECIDE = 5'd12;
  localparam logic [4:0] ST_PUSH1  = 5'd13;
  localparam logic [4:0] ST_PUSH2  = 5'd14;
  localparam logic [4:0] ST_EMIT   = 5'd15;

  localparam logic [4:0] J_THR2  = 5'd0;
  localparam logic [4:0] J_DD0   = 5'd1;
  localparam logic [4:0] J_DD1   = 5'd2;
  localparam logic [4:0] J_DD2   = 5'd3;
  localparam logic [4:0] J_THR   = 5'd4;
  localparam logic [4:0] J_VV0   = 5'd5;
  localparam logic [4:0] J_VV1   = 5'd6;
  localparam logic [4:0] J_VV2   = 5'd7;
  localparam logic [4:0] J_DOT0  = 5'd8;
  localparam logic [4:0] J_DOT1  = 5'd9;
  localparam logic [4:0] J_DOT2  = 5'd10;
  localparam logic [4:0] J_VE0   = 5'd11;
  localparam logic [4:0] J_VE1   = 5'd12;
  localparam logic [4:0] J_VE2   = 5'd13;
  localparam logic [4:0] J_VVDD  = 5'd14;
  localparam logic [4:0] J_VVDDS = 5'd15;
  localparam logic [4:0] J_DSQ   = 5'd16;

  function automatic logic [MW-1:0] mag_f(input logic signed [DW-1:0] v);
    logic [DW-1:0] u;
    u = v[DW-1] ? DW'(-v) : DW'(v);
    return MW'(u);
  endfunction

  // Control registers
  logic [4:0]            state_r, state_nxt;
  logic [4:0]            job_r, job_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [CW-1:0]         level_r, level_nxt;
  logic [MAX_POINTS-1:0] rem_r, rem_nxt;
  logic [MAX_POINTS-1:0] kept_r, kept_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [MAX_ERR_W-1:0]  max_error_r, max_error_nxt;
  logic                  closed_r, closed_nxt;

  // Datapath registers
  logic [KEPT_W-1:0]      out_idx_r, out_idx_nxt;
  logic                   out_final_r, out_final_nxt;
  logic [THR2_W-1:0]      thr2_r, thr2_nxt;
  logic [PW-1:0]          thr_r, thr_nxt;
  logic [MW-1:0]          dd_r, dd_nxt;
  logic [MW-1:0]          vv_r, vv_nxt;
  logic [MW:0]            dot_r, dot_nxt;
  logic [AW-1:0]          acc_r, acc_nxt;
  logic [PW-1:0]          d_r, d_nxt;
  logic [PW-1:0]          best_r, best_nxt;
  logic                   found_r, found_nxt;
  logic [IW-1:0]          best_i_r, best_i_nxt;
  logic [IW-1:0]          s_r, s_nxt;
  logic [IW-1:0]          e_r, e_nxt;
  logic [IW-1:0]          i_r, i_nxt;
  logic [IW-1:0]          j_r, j_nxt;
  logic signed [COORD_BITS-1:0] sx_r, sx_nxt, sy_r, sy_nxt, sz_r, sz_nxt;
  logic signed [DW-1:0]   dx_r, dx_nxt, dy_r, dy_nxt, dz_r, dz_nxt;
  logic signed [DW-1:0]   vx_r, vx_nxt, vy_r, vy_nxt, vz_r, vz_nxt;

  // Memories
  logic [PTW-1:0] pt_mem [MAX_POINTS];
  logic [PTW-1:0] pt_q;
  logic [IW-1:0]  pt_raddr;
  logic           pt_we;
  logic [SEW-1:0] stk_mem [MAX_POINTS];
  logic [SEW-1:0] stk_q;
  logic [IW-1:0]  stk_raddr;
  logic           stk_we;
  logic [SEW-1:0] stk_wdata;

  // Shared multiplier
  logic          mul_start, mul_done;
  logic [MW-1:0] mul_a, mul_b;
  logic [PW-1:0] mul_p;
  logic          acc_first, acc_sub;
  logic [AW-1:0] acc_base, acc_new;

  logic signed [COORD_BITS-1:0] px, py, pz;
  logic signed [DW-1:0]         vex, vey, vez;
  logic [MAX_POINTS-1:0]        kept_small, kept_big, kept_above;
  logic [CW-1:0]                last_cnt;
  logic                         in_acc, slot_free, dot_le0;

  assign px = pt_q[PTW-1 -: COORD_BITS];
  assign py = pt_q[2*COORD_BITS-1 -: COORD_BITS];
  assign pz = pt_q[COORD_BITS-1:0];

  // Offsets from the span end follow from the two registered differences.
  assign vex = vx_r - dx_r;
  assign vey = vy_r - dy_r;
  assign vez = vz_r - dz_r;

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign in_acc            = in_ch.valid && (state_r == ST_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.kept_index = out_idx_r;
  assign out_ch.final_kept = out_final_r;
  assign slot_free         = !out_valid_r || out_ch.ready;
  assign kept_above        = kept_r >> j_r;
  assign last_cnt          = count_r - CW'(1);
  assign mul_start         = (state_r == ST_MGO);
  assign stk_raddr         = IW'(level_r - CW'(1));

  rdp_mul #(.W(MW)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  always_comb begin
    mul_a     = mag_f(dx_r);
    mul_b     = mag_f(dx_r);
    acc_first = 1'b1;
    acc_sub   = 1'b0;
    unique case (job_r)
      J_THR2: begin
        mul_a = MW'(max_error_r);
        mul_b = MW'(max_error_r);
      end
      J_DD0: ;
      J_DD1: begin
        mul_a = mag_f(dy_r); mul_b = mag_f(dy_r); acc_first = 1'b0;
      end
      J_DD2: begin
        mul_a = mag_f(dz_r); mul_b = mag_f(dz_r); acc_first = 1'b0;
      end
      J_THR: begin
        mul_a = MW'(thr2_r);
        mul_b = (dd_r == '0) ? MW'(1) : dd_r;
      end
      J_VV0: begin
        mul_a = mag_f(vx_r); mul_b = mag_f(vx_r);
      end
      J_VV1: begin
        mul_a = mag_f(vy_r); mul_b = mag_f(vy_r); acc_first = 1'b0;
      end
      J_VV2: begin
        mul_a = mag_f(vz_r); mul_b = mag_f(vz_r); acc_first = 1'b0;
      end
      J_DOT0: begin
        mul_a = mag_f(vx_r); mul_b = mag_f(dx_r);
        acc_sub = vx_r[DW-1] ^ dx_r[DW-1];
      end
      J_DOT1: begin
        mul_a = mag_f(vy_r); mul_b = mag_f(dy_r); acc_first = 1'b0;
        acc_sub = vy_r[DW-1] ^ dy_r[DW-1];
      end
      J_DOT2: begin
        mul_a = mag_f(vz_r); mul_b = mag_f(dz_r); acc_first = 1'b0;
        acc_sub = vz_r[DW-1] ^ dz_r[DW-1];
      end
      J_VE0: begin
        mul_a = mag_f(vex); mul_b = mag_f(vex);
      end
      J_VE1: begin
        mul_a = mag_f(vey); mul_b = mag_f(vey); acc_first = 1'b0;
      end
      J_VE2: begin
        mul_a = mag_f(vez); mul_b = mag_f(vez); acc_first = 1'b0;
      end
      J_VVDD, J_VVDDS: begin
        mul_a = vv_r; mul_b = dd_r;
      end
      J_DSQ: begin
        mul_a = dot_r[MW-1:0]; mul_b = dot_r[MW-1:0];
        acc_first = 1'b0; acc_sub = 1'b1;
      end
      default: ;
    endcase
    acc_base = acc_first ? '0 : acc_r;
    acc_new  = acc_sub ? (acc_base - AW'(mul_p)) : (acc_base + AW'(mul_p));
  end

  assign dot_le0 = acc_new[AW-1] || (acc_new == '0);

  // Initial keep sets: short lines keep everything, others keep the fixed points.
  always_comb begin
    for (int k = 0; k < MAX_POINTS; k++) begin
      kept_small[k] = (CW'(k) < count_r);
      kept_big[k]   = (k == 0) || ((CW'(k) == last_cnt) && !closed_r) ||
                      ((k >= 1) && (CW'(k) < count_r) && !rem_r[k] &&
                       ((CW'(k) < last_cnt) || closed_r));
    end
  end

  always_comb begin
    state_nxt     = state_r;
    job_nxt       = job_r;
    count_nxt     = count_r;
    level_nxt     = level_r;
    rem_nxt       = rem_r;
    kept_nxt      = kept_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    max_error_nxt = max_error_r;
    closed_nxt    = closed_r;
    out_idx_nxt   = out_idx_r;
    out_final_nxt = out_final_r;
    thr2_nxt      = thr2_r;
    thr_nxt       = thr_r;
    dd_nxt        = dd_r;
    vv_nxt        = vv_r;
    dot_nxt       = dot_r;
    acc_nxt       = acc_r;
    d_nxt         = d_r;
    best_nxt      = best_r;
    found_nxt     = found_r;
    best_i_nxt    = best_i_r;
    s_nxt         = s_r;
    e_nxt         = e_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    sx_nxt = sx_r; sy_nxt = sy_r; sz_nxt = sz_r;
    dx_nxt = dx_r; dy_nxt = dy_r; dz_nxt = dz_r;
    vx_nxt = vx_r; vy_nxt = vy_r; vz_nxt = vz_r;
    pt_we     = 1'b0;
    pt_raddr  = s_r;
    stk_we    = 1'b0;
    stk_wdata = {best_i_r, e_r};

    if (cfg_we) begin
      unique case (cfg_addr)
        CFG_MAX_ERROR:   max_error_nxt = cfg_wdata[MAX_ERR_W-1:0];
        CFG_CLOSED_PATH: closed_nxt    = cfg_wdata[0];
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (count_r < CW'(MAX_POINTS)) begin
            pt_we = 1'b1;
            rem_nxt[count_r[IW-1:0]] = in_ch.removable;
            count_nxt = count_r + CW'(1);
          end
          if (in_ch.end_of_line) begin
            job_nxt   = J_THR2;
            state_nxt = ST_MGO;
          end
        end
      end
      ST_INIT: begin
        if (count_r < CW'(3)) begin
          kept_nxt  = kept_small;
          j_nxt     = '0;
          state_nxt = ST_EMIT;
        end else begin
          kept_nxt  = kept_big;
          stk_we    = 1'b1;
          stk_wdata = {IW'(0), IW'(last_cnt)};
          level_nxt = CW'(1);
          state_nxt = ST_POP;
        end
      end
      ST_POP: begin
        if (level_r == '0) begin
          j_nxt     = '0;
          state_nxt = ST_EMIT;
        end else begin
          level_nxt = level_r - CW'(1);
          state_nxt = ST_SPAN;
        end
      end
      ST_SPAN: begin
        s_nxt     = stk_q[SEW-1:IW];
        e_nxt     = stk_q[IW-1:0];
        state_nxt = ST_RDS;
      end
      ST_RDS: begin
        pt_raddr  = s_r;
        state_nxt = ST_RDE;
      end
      ST_RDE: begin
        sx_nxt = px; sy_nxt = py; sz_nxt = pz;
        pt_raddr  = e_r;
        state_nxt = ST_DIFF;
      end
      ST_DIFF: begin
        dx_nxt    = DW'(px) - DW'(sx_r);
        dy_nxt    = DW'(py) - DW'(sy_r);
        dz_nxt    = DW'(pz) - DW'(sz_r);
        job_nxt   = J_DD0;
        state_nxt = ST_MGO;
      end
      ST_MGO: begin
        state_nxt = ST_MWAIT;
      end
      ST_MWAIT: begin
        if (mul_done) begin
          acc_nxt   = acc_new;
          state_nxt = ST_MGO;
          unique case (job_r)
            J_THR2: begin
              thr2_nxt  = mul_p[THR2_W-1:0];
              state_nxt = ST_INIT;
            end
            J_DD0: job_nxt = J_DD1;
            J_DD1: job_nxt = J_DD2;
            J_DD2: begin
              dd_nxt  = acc_new[MW-1:0];
              job_nxt = J_THR;
            end
            J_THR: begin
              thr_nxt   = mul_p;
              i_nxt     = s_r + IW'(1);
              best_nxt  = '0;
              found_nxt = 1'b0;
              state_nxt = ST_CAND;
            end
            J_VV0: job_nxt = J_VV1;
            J_VV1: job_nxt = J_VV2;
            J_VV2: begin
              vv_nxt = acc_new[MW-1:0];
              if (dd_r == '0) begin
                // Degenerate segment: the distance to its start stands alone.
                d_nxt     = acc_new[PW-1:0];
                state_nxt = ST_CMP;
              end else begin
                job_nxt = J_DOT0;
              end
            end
            J_DOT0: job_nxt = J_DOT1;
            J_DOT1: job_nxt = J_DOT2;
            J_DOT2: begin
              dot_nxt = acc_new[MW:0];
              if (dot_le0)                          job_nxt = J_VVDD;
              else if (acc_new[MW-1:0] >= dd_r)     job_nxt = J_VE0;
              else                                  job_nxt = J_VVDDS;
            end
            J_VE0: job_nxt = J_VE1;
            J_VE1: job_nxt = J_VE2;
            J_VE2: begin
              vv_nxt  = acc_new[MW-1:0];
              job_nxt = J_VVDD;
            end
            J_VVDD, J_DSQ: begin
              d_nxt     = acc_new[PW-1:0];
              state_nxt = ST_CMP;
            end
            J_VVDDS: job_nxt = J_DSQ;
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_CAND: begin
        pt_raddr = i_r;
        if (i_r >= e_r)     state_nxt = ST_DECIDE;
        else if (!rem_r[i_r]) i_nxt   = i_r + IW'(1);
        else                state_nxt = ST_CV;
      end
      ST_CV: begin
        vx_nxt    = DW'(px) - DW'(sx_r);
        vy_nxt    = DW'(py) - DW'(sy_r);
        vz_nxt    = DW'(pz) - DW'(sz_r);
        job_nxt   = J_VV0;
        state_nxt = ST_MGO;
      end
      ST_CMP: begin
        if (d_r > best_r) begin
          best_nxt   = d_r;
          best_i_nxt = i_r;
          found_nxt  = 1'b1;
        end
        i_nxt     = i_r + IW'(1);
        state_nxt = ST_CAND;
      end
      ST_DECIDE: begin
        if (found_r && (best_r > thr_r)) begin
          kept_nxt[best_i_r] = 1'b1;
          state_nxt = ST_PUSH1;
        end else begin
          state_nxt = ST_POP;
        end
      end
      ST_PUSH1: begin
        stk_wdata = {best_i_r, e_r};
        if (((e_r - best_i_r) > IW'(1)) && (level_r < CW'(MAX_POINTS))) begin
          stk_we    = 1'b1;
          level_nxt = level_r + CW'(1);
        end
        state_nxt = ST_PUSH2;
      end
      ST_PUSH2: begin
        stk_wdata = {s_r, best_i_r};
        if (((best_i_r - s_r) > IW'(1)) && (level_r < CW'(MAX_POINTS))) begin
          stk_we    = 1'b1;
          level_nxt = level_r + CW'(1);
        end
        state_nxt = ST_POP;
      end
      ST_EMIT: begin
        if (slot_free) begin
          if (kept_r[j_r]) begin
            out_valid_nxt = 1'b1;
            out_idx_nxt   = KEPT_W'(j_r);
            out_final_nxt = ((kept_above >> 1) == '0);
          end
          if (j_r == IW'(MAX_POINTS - 1)) begin
            count_nxt = '0;
            level_nxt = '0;
            rem_nxt   = '0;
            kept_nxt  = '0;
            state_nxt = ST_IDLE;
          end else begin
            j_nxt = j_r + IW'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      job_r       <= J_THR2;
      count_r     <= '0;
      level_r     <= '0;
      rem_r       <= '0;
      kept_r      <= '0;
      out_valid_r <= 1'b0;
      max_error_r <= MAX_ERR_W'(MAX_ERR_RST);
      closed_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      job_r       <= job_nxt;
      count_r     <= count_nxt;
      level_r     <= level_nxt;
      rem_r       <= rem_nxt;
      kept_r      <= kept_nxt;
      out_valid_r <= out_valid_nxt;
      max_error_r <= max_error_nxt;
      closed_r    <= closed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_idx_r   <= out_idx_nxt;
    out_final_r <= out_final_nxt;
    thr2_r      <= thr2_nxt;
    thr_r       <= thr_nxt;
    dd_r        <= dd_nxt;
    vv_r        <= vv_nxt;
    dot_r       <= dot_nxt;
    acc_r       <= acc_nxt;
    d_r         <= d_nxt;
    best_r      <= best_nxt;
    found_r     <= found_nxt;
    best_i_r    <= best_i_nxt;
    s_r         <= s_nxt;
    e_r         <= e_nxt;
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    sx_r <= sx_nxt; sy_r <= sy_nxt; sz_r <= sz_nxt;
    dx_r <= dx_nxt; dy_r <= dy_nxt; dz_r <= dz_nxt;
    vx_r <= vx_nxt; vy_r <= vy_nxt; vz_r <= vz_nxt;
  end

  always_ff @(posedge clk) begin
    if (pt_we) pt_mem[count_r[IW-1:0]] <= {in_ch.pos_x, in_ch.pos_y, in_ch.pos_z};
    pt_q <= pt_mem[pt_raddr];
  end

  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[level_r[IW-1:0]] <= stk_wdata;
    stk_q <= stk_mem[stk_raddr];
  end

endmodule

/* rtl/rdp_checker.sv */
// Port-level checks for the polyline simplifier, bound to the top level.
module rdp_checker
  import rdp_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              in_eol,
  input logic              out_valid,
  input logic              out_ready,
  input logic [KEPT_W-1:0] out_index,
  input logic              out_final
);

  logic              pend_r, first_r, prev_vld_r;
  logic [KEPT_W-1:0] prev_idx_r;
  logic              eol_acc, out_acc;

  assign eol_acc = in_valid && in_ready && in_eol;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r     <= 1'b0;
      first_r    <= 1'b0;
      prev_vld_r <= 1'b0;
    end else begin
      pend_r     <= (pend_r && !(out_valid && out_final)) || eol_acc;
      first_r    <= (first_r && !out_acc) || eol_acc;
      prev_vld_r <= out_acc ? !out_final : prev_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_acc) prev_idx_r <= out_index;
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_index) && $stable(out_final))
    else $error("result word changed while stalled");

  a_no_load_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r && !(out_valid && out_final) |-> !in_ready)
    else $error("point accepted before the line was fully reported");

  a_first_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && first_r |-> out_index == '0)
    else $error("first kept index of a line is not zero");

  a_ascending: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && prev_vld_r |-> out_index > prev_idx_r)
    else $error("kept indices not ascending");

endmodule

bind polyline_douglas_peucker_simplifier_core rdp_checker u_rdp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_eol    (in_ch.end_of_line),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_index (out_ch.kept_index),
  .out_final (out_ch.final_kept)
);
